### rtl/core/cvw_pkg.sv
// Shared types and constants for the 3x3 valid-window convolution stream unit.
`default_nettype none
package cvw_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  localparam int DIM_W     = 11;
  localparam int KDIM_W    = 2;
  localparam int SAMPLE_W  = 16;
  localparam int WROW_W    = 48;
  localparam int BIAS_W    = 32;
  localparam int VALUE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int TAPS      = 9;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0]  RST_IMAGE_DIM = 11'd1024;
  localparam logic [KDIM_W-1:0] RST_KERNEL_DIM = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_COLS  = 3'd2,
    REG_KERNEL_ROWS  = 3'd3,
    REG_WEIGHTS_ROW0 = 3'd4,
    REG_WEIGHTS_ROW1 = 3'd5,
    REG_WEIGHTS_ROW2 = 3'd6,
    REG_BIAS_VALUE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]           image_width;
    logic [DIM_W-1:0]           image_height;
    logic [KDIM_W-1:0]          kernel_cols;
    logic [KDIM_W-1:0]          kernel_rows;
    logic [2:0][WROW_W-1:0]     weights;
    logic signed [BIAS_W-1:0]   bias;
  } cfg_t;

  typedef struct packed {
    logic [TAPS-1:0][SAMPLE_W-1:0] taps;
    logic                          last;
  } win_t;

endpackage
`default_nettype wire

### rtl/core/cvw_queue.sv
// Short FIFO of aligned windows between the front and the arithmetic back end.
`default_nettype none
module cvw_queue
  import cvw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire win_t              push_data,
  input  wire logic              pop,
  output logic                   q_valid,
  output win_t                   q_data,
  output logic [QCNT_W-1:0]      q_count
);

  win_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  assign q_valid = (q_count != '0);
  assign q_data  = slots[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        q_count <= q_count + 1'b1;
      end else if (!push && do_pop) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/cvw_front.sv
// Front end: sample intake, frame counters, line buffer, window and result classification.
`default_nettype none
module cvw_front
  import cvw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  restart,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic [QCNT_W-1:0]     q_count,
  output logic                       push,
  output win_t                       push_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int DWW = (WW > DIM_W) ? WW : DIM_W;
  localparam int DWH = (HW > DIM_W) ? HW : DIM_W;

  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [DWW-1:0]    w_ext;
  logic [DWH-1:0]    h_ext;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [CW-1:0]     col_last;
  logic [RW-1:0]     row_last;
  logic [KDIM_W-1:0] kc_eff;
  logic [KDIM_W-1:0] kr_eff;
  logic              accept;
  logic              fits;
  logic              has_result;
  logic              is_last;
  logic [QCNT_W:0]   credit_used;

  logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_W-1:0] rdata;
  logic [2*SAMPLE_W-1:0] wdata;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [CW-1:0]       s1_col;
  logic                s1_res;
  logic                s1_last;

  logic [SAMPLE_W-1:0] win      [3][3];
  logic [SAMPLE_W-1:0] win_next [3][3];

  always_comb begin
    w_ext = DWW'(cfg.image_width);
    h_ext = DWH'(cfg.image_height);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > DWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > DWH'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  assign col_last = CW'(w_eff - 1'b1);
  assign row_last = RW'(h_eff - 1'b1);
  assign kc_eff   = (cfg.kernel_cols == '0) ? KDIM_W'(1) : cfg.kernel_cols;
  assign kr_eff   = (cfg.kernel_rows == '0) ? KDIM_W'(1) : cfg.kernel_rows;

  assign credit_used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid);
  assign in_ready    = credit_used < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept      = in_valid && in_ready;

  assign fits       = (WW'(kc_eff) <= w_eff) && (HW'(kr_eff) <= h_eff);
  assign has_result = fits && (col >= CW'(kc_eff - 1'b1)) && (row >= RW'(kr_eff - 1'b1));
  assign is_last    = (col == col_last) && (row == row_last);

  // advance frame position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  assign wdata = {rdata[SAMPLE_W-1:0], s1_sample};

  // line buffer: high half two rows back, low half previous row
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= wdata;
    end
    if (accept) begin
      rdata <= (s1_valid && s1_col == col) ? wdata : line_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= sample;
      s1_col    <= col;
      s1_res    <= has_result;
      s1_last   <= is_last;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = rdata[2*SAMPLE_W-1:SAMPLE_W];
    win_next[1][2] = rdata[SAMPLE_W-1:0];
    win_next[2][2] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // align the kernel's window to tap (0,0) and zero the unused taps
  always_comb begin
    logic [1:0] wr;
    logic [1:0] wc;
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        wr = 2'(ky + 3 - int'(kr_eff));
        wc = 2'(kx + 3 - int'(kc_eff));
        if (ky < int'(kr_eff) && kx < int'(kc_eff)) begin
          push_data.taps[ky*3+kx] = win_next[wr][wc];
        end else begin
          push_data.taps[ky*3+kx] = '0;
        end
      end
    end
    push_data.last = s1_last;
  end

  assign push = s1_valid && s1_res;

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> (col == '0 && row == '0))
    else $error("frame position not cleared after geometry write");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= col_last)
    else $error("column position beyond row length");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= row_last)
    else $error("row position beyond frame height");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !push)
    else $error("window pushed into a full queue");
`endif

endmodule
`default_nettype wire

### rtl/core/cvw_back.sv
// Back end: nine products, adder tree with bias, saturation and output register.
`default_nettype none
module cvw_back
  import cvw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_valid,
  input  wire win_t                 q_data,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic                      frame_last
);

  localparam int PW = 2 * SAMPLE_W;
  localparam int SW = PW + 2;
  localparam int TW = SW + 2;
  localparam logic signed [TW-1:0] SAT_HI = TW'(64'sh7FFF_FFFF);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(64'sh8000_0000);

  logic                 adv;
  logic                 p_valid;
  logic                 p_last;
  logic signed [PW-1:0] prod [TAPS];
  logic                 s_valid;
  logic                 s_last;
  logic signed [SW-1:0] rsum [3];
  logic signed [TW-1:0] total;

  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  for (genvar i = 0; i < TAPS; i++) begin : g_mul
    localparam int KY = i / 3;
    localparam int KX = i % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[i] <= $signed(q_data.taps[i]) *
                   $signed(cfg.weights[KY][KX*SAMPLE_W +: SAMPLE_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_last  <= q_data.last;
      rsum[0] <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
      rsum[1] <= SW'(prod[3]) + SW'(prod[4]) + SW'(prod[5]);
      rsum[2] <= SW'(prod[6]) + SW'(prod[7]) + SW'(prod[8]) + SW'(cfg.bias);
      s_last  <= p_last;
    end
  end

  assign total = TW'(rsum[0]) + TW'(rsum[1]) + TW'(rsum[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_last <= s_last;
      if (total > SAT_HI) begin
        value <= VALUE_W'(SAT_HI);
      end else if (total < SAT_LO) begin
        value <= VALUE_W'(SAT_LO);
      end else begin
        value <= VALUE_W'(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p_valid   <= q_valid;
      s_valid   <= p_valid;
      out_valid <= s_valid;
    end
  end

endmodule
`default_nettype wire

### rtl/core/conv2d_valid_window_stream_unit.sv
// Top level of the streaming 3x3 valid-window convolution unit with its register file.
// Takes one signed Q8.8 sample per cycle in raster order while in_ready is high, and
// gives one Q16.16 result (saturated to 32 bits, bias added) per valid kernel position,
// with frame_last on the frame's final result; intake is bound by the single read and
// single write per cycle of the line-buffer memory (MAX_WIDTH words of two samples). A
// four-entry queue separates the line-buffer front from the multiply-add back end, so a
// held output stalls intake only once the queue's entries plus the front's pending
// sample reach its depth. The line buffer needs no clearing after reset. Configuration
// writes are taken at any time but belong between frames; a write to width, height or
// kernel size restarts the frame position.
`default_nettype none
module conv2d_valid_window_stream_unit
  import cvw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [VALUE_W-1:0]  value,
  output logic                       frame_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WROW_W-1:0]     cfg_data
);

  cfg_t              cfg;
  logic              cfg_write;
  logic              restart;
  logic              push;
  win_t              push_data;
  logic              pop;
  logic              q_valid;
  win_t              q_data;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    unique case (reg_idx_t'(cfg_index))
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
      REG_KERNEL_COLS, REG_KERNEL_ROWS: restart = cfg_write;
      REG_WEIGHTS_ROW0, REG_WEIGHTS_ROW1,
      REG_WEIGHTS_ROW2, REG_BIAS_VALUE: restart = 1'b0;
      default:                          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_DIM;
      cfg.image_height <= RST_IMAGE_DIM;
      cfg.kernel_cols  <= RST_KERNEL_DIM;
      cfg.kernel_rows  <= RST_KERNEL_DIM;
      cfg.weights      <= '0;
      cfg.bias         <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        REG_KERNEL_COLS:  cfg.kernel_cols  <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_ROWS:  cfg.kernel_rows  <= cfg_data[KDIM_W-1:0];
        REG_WEIGHTS_ROW0: cfg.weights[0]   <= cfg_data;
        REG_WEIGHTS_ROW1: cfg.weights[1]   <= cfg_data;
        REG_WEIGHTS_ROW2: cfg.weights[2]   <= cfg_data;
        REG_BIAS_VALUE:   cfg.bias         <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  cvw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  cvw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  cvw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .frame_last (frame_last)
  );

endmodule
`default_nettype wire

### verif/conv2d_window_checker.sv
// Checker for the convolution stream unit: tracks register writes, predicts results, compares beats.
module conv2d_window_checker
  import cvw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 frame_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WROW_W-1:0]    cfg_data,
  output int                   results_due,
  output int                   mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } conv_result_t;

  logic [DIM_W-1:0]           img_w;
  logic [DIM_W-1:0]           img_h;
  logic [KDIM_W-1:0]          ker_c;
  logic [KDIM_W-1:0]          ker_r;
  logic [WROW_W-1:0]          ker_w [3];
  logic signed [BIAS_W-1:0]   bias_q;
  logic [SAMPLE_W-1:0]        row_prev [MAX_WIDTH];
  logic [SAMPLE_W-1:0]        row_older [MAX_WIDTH];
  logic signed [SAMPLE_W-1:0] win [3][3];
  int unsigned                col_pos;
  int unsigned                row_pos;
  conv_result_t               due_results [$];
  int                         fails = 0;

  assign mismatch_count = fails;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  task automatic correlate_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned w, h, kc, kr, c, r, k, ky, kx;
    longint acc;
    conv_result_t res;
    w  = clamp_dim(img_w, MAX_WIDTH);
    h  = clamp_dim(img_h, MAX_HEIGHT);
    kc = (ker_c == 0) ? 1 : ker_c;
    kr = (ker_r == 0) ? 1 : ker_r;
    c  = (col_pos >= w) ? 0 : col_pos;
    r  = (row_pos >= h) ? 0 : row_pos;
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = row_older[c];
    win[1][2] = row_prev[c];
    win[2][2] = s;
    row_older[c] = row_prev[c];
    row_prev[c]  = s;
    if (kr <= h && kc <= w && r + 1 >= kr && c + 1 >= kc) begin
      acc = bias_q;
      for (ky = 0; ky < kr; ky++) begin
        for (kx = 0; kx < kc; kx++) begin
          acc += longint'(win[3 - kr + ky][3 - kc + kx]) *
                 longint'($signed(ker_w[ky][SAMPLE_W*kx +: SAMPLE_W]));
        end
      end
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      res.value = acc[VALUE_W-1:0];
      res.last  = (r == h - 1) && (c == w - 1);
      due_results.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      img_w  = RST_IMAGE_DIM;
      img_h  = RST_IMAGE_DIM;
      ker_c  = RST_KERNEL_DIM;
      ker_r  = RST_KERNEL_DIM;
      ker_w  = '{'0, '0, '0};
      bias_q = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_prev[i]  = '0;
        row_older[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      col_pos = 0;
      row_pos = 0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with none due: value %0d frame_last %0b",
                   $time, $signed(value), frame_last);
        end else begin
          want = due_results.pop_front();
          if (value !== want.value) begin
            fails++;
            $display("%0t: value expected %0d got %0d",
                     $time, $signed(want.value), $signed(value));
          end
          if (frame_last !== want.last) begin
            fails++;
            $display("%0t: frame_last expected %0b got %0b", $time, want.last, frame_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_IMAGE_WIDTH:  img_w = cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: img_h = cfg_data[DIM_W-1:0];
          REG_KERNEL_COLS:  ker_c = cfg_data[KDIM_W-1:0];
          REG_KERNEL_ROWS:  ker_r = cfg_data[KDIM_W-1:0];
          REG_WEIGHTS_ROW0: ker_w[0] = cfg_data;
          REG_WEIGHTS_ROW1: ker_w[1] = cfg_data;
          REG_WEIGHTS_ROW2: ker_w[2] = cfg_data;
          REG_BIAS_VALUE:   bias_q = cfg_data[BIAS_W-1:0];
          default: ;
        endcase
        if (reg_idx_t'(cfg_index) inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                          REG_KERNEL_COLS, REG_KERNEL_ROWS}) begin
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (in_valid && in_ready) correlate_sample(sample);
    end
    results_due <= due_results.size();
  end

endmodule

### verif/tb.sv
// Testbench top: drives samples and register writes into the convolution stream unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvw_pkg::*;

  localparam int MAX_W         = DEFAULT_MAX_WIDTH;
  localparam int MAX_H         = DEFAULT_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 9;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SAMPLE_W-1:0]       sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      frame_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [WROW_W-1:0]         cfg_data = '0;
  int                        results_due;
  int                        mismatch_count;
  int                        snd_idle_pct = 30;
  int                        rcv_idle_pct = 48;
  logic [WROW_W-1:0]         reg_image [8];

  conv2d_valid_window_stream_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  conv2d_window_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .frame_last     (frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim(input int unsigned span);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 11'd1;
      2: return '1;
      default: return DIM_W'($urandom_range(1, span));
    endcase
  endfunction

  function automatic logic [BIAS_W-1:0] rand_bias();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return BIAS_W'($signed($urandom) >>> $urandom_range(0, 24));
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_config(input logic [7:0] mask);
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx_t'(i);
        cfg_data  <= reg_image[i];
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    for (int i = 0; i < 8; i++) reg_image[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 image, full kernel at most negative weights: saturate high
    reg_image[REG_IMAGE_WIDTH]  = 48'd3;
    reg_image[REG_IMAGE_HEIGHT] = 48'd3;
    reg_image[REG_KERNEL_COLS]  = 48'd3;
    reg_image[REG_KERNEL_ROWS]  = 48'd3;
    reg_image[REG_WEIGHTS_ROW0] = {3{16'h8000}};
    reg_image[REG_WEIGHTS_ROW1] = {3{16'h8000}};
    reg_image[REG_WEIGHTS_ROW2] = {3{16'h8000}};
    reg_image[REG_BIAS_VALUE]   = 48'h7FFF_FFFF;
    load_config(8'hFF);
    repeat (9) push_sample(16'h8000);
    settle();

    // swap weights and bias only: saturate low
    reg_image[REG_WEIGHTS_ROW0] = {3{16'h7FFF}};
    reg_image[REG_WEIGHTS_ROW1] = {3{16'h7FFF}};
    reg_image[REG_WEIGHTS_ROW2] = {3{16'h7FFF}};
    reg_image[REG_BIAS_VALUE]   = 48'hFFFF_8000_0000;
    load_config(8'hF0);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    repeat (4) push_sample(16'h8000);
    settle();

    // kernel larger than the image: no results
    reg_image[REG_IMAGE_WIDTH]  = 48'd2;
    reg_image[REG_IMAGE_HEIGHT] = 48'd2;
    load_config(8'h0F);
    push_sample(16'h5555);
    push_sample(16'hAAAA);
    push_sample(16'h0001);
    push_sample(16'hFFFE);
    settle();

    // zero geometry and zero kernel size act as one
    reg_image[REG_IMAGE_WIDTH]  = 48'd0;
    reg_image[REG_IMAGE_HEIGHT] = 48'd0;
    reg_image[REG_KERNEL_COLS]  = 48'd0;
    reg_image[REG_KERNEL_ROWS]  = 48'd0;
    load_config(8'h0F);
    repeat (3) push_sample(rand_sample());
    settle();

    for (int p = 0; p < PHASES; p++) begin
      snd_idle_pct = (p < 3) ? 30 : (p < 6) ? 48 : 0;
      rcv_idle_pct = (p < 3) ? 48 : (p < 6) ? 30 : 0;
      for (int i = 0; i < 8; i++) reg_image[i] = WROW_W'({$urandom, $urandom});
      reg_image[REG_IMAGE_WIDTH][DIM_W-1:0]   = rand_dim(8);
      reg_image[REG_IMAGE_HEIGHT][DIM_W-1:0]  = rand_dim(6);
      reg_image[REG_KERNEL_COLS][KDIM_W-1:0]  = KDIM_W'($urandom_range(0, 3));
      reg_image[REG_KERNEL_ROWS][KDIM_W-1:0]  = KDIM_W'($urandom_range(0, 3));
      reg_image[REG_WEIGHTS_ROW0] = {rand_sample(), rand_sample(), rand_sample()};
      reg_image[REG_WEIGHTS_ROW1] = {rand_sample(), rand_sample(), rand_sample()};
      reg_image[REG_WEIGHTS_ROW2] = {rand_sample(), rand_sample(), rand_sample()};
      reg_image[REG_BIAS_VALUE][BIAS_W-1:0] = rand_bias();
      if (p == 1) begin
        reg_image[REG_IMAGE_WIDTH][DIM_W-1:0]  = '1;
        reg_image[REG_KERNEL_ROWS][KDIM_W-1:0] = 2'd1;
      end
      if (p == 4) begin
        reg_image[REG_IMAGE_WIDTH][DIM_W-1:0]  = 11'd5;
        reg_image[REG_IMAGE_HEIGHT][DIM_W-1:0] = '1;
      end
      load_config((p % 3 == 2) ? 8'hF0 : 8'hFF);
      n = $urandom_range(35, 65);
      repeat (n) push_sample(rand_sample());
      settle();
    end

    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
